// ===== design/mpgd_pkg.sv =====
// Package for the max pooling grid downsampler.
// Holds the register indexes, field widths and the control word passed between stages.
// No dependencies.
`default_nettype none

package mpgd_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_FACTOR   = 2'd2;

  localparam int SIZE_FIELD_W   = 12;
  localparam int FACTOR_FIELD_W = 5;
  localparam int HEIGHT_LIMIT   = 2048;

  localparam int VALUE_W    = 8;
  localparam int COORD_W    = 11;
  localparam int ROW_W      = 11;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_PAD_W  = OUT_DATA_W - VALUE_W - 2 * COORD_W;

  typedef struct packed {
    logic use_line;
    logic store;
    logic emit;
    logic frame_end;
  } mpgd_ctl_t;

endpackage

`default_nettype wire

// ===== design/max_pool_grid_downsample.sv =====
// Streaming 2-D max pooling of a signed 8-bit grid: one cell accepted per clock cycle unless a
// pooled cell waits behind a stalled output; a completed block's result goes through s1 to out_.
// The rate is set by the line store, whose single write port and single read port carry one
// read-modify-write of a partial column maximum each cycle; a read of the column that is
// written in the same cycle is forwarded. A stalled output register holds one pooled cell
// while a further item is still taken in. Uses mpgd_pkg, mpgd_scan and mpgd_line_store.
`default_nettype none

module max_pool_grid_downsample
  import mpgd_pkg::*;
#(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_FACTOR = 16
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    cfg_we,
  input  wire [CFG_IDX_W-1:0]    cfg_index,
  input  wire [CFG_DATA_W-1:0]   cfg_wdata,
  input  wire                    in_tvalid,
  output logic                   in_tready,
  input  wire [VALUE_W-1:0]      in_tdata,    // cell_value
  output logic                   out_tvalid,
  input  wire                    out_tready,
  output logic [OUT_DATA_W-1:0]  out_tdata,   // pooled_value, target_col, target_row, zeros
  output logic                   out_tlast    // frame_last
);

  localparam int COL_W = $clog2(MAX_WIDTH);

  mpgd_ctl_t                 scan_ctl;
  logic [COL_W-1:0]          scan_col;
  logic [ROW_W-1:0]          scan_row;
  logic signed [VALUE_W-1:0] scan_max;

  logic                      accept;
  logic                      advance;

  logic                      s1_valid_r;
  mpgd_ctl_t                 s1_ctl_r;
  logic [COL_W-1:0]          s1_col_r;
  logic [ROW_W-1:0]          s1_row_r;
  logic signed [VALUE_W-1:0] s1_max_r;
  logic                      s1_fwd_r, s1_fwd_nxt;
  logic signed [VALUE_W-1:0] s1_fwd_data_r;

  logic                      mem_wr_en;
  logic                      mem_rd_en;
  logic signed [VALUE_W-1:0] mem_rd_data;
  logic signed [VALUE_W-1:0] line_val;
  logic signed [VALUE_W-1:0] combined;
  logic [31:0]               col_ext;

  logic                      out_tvalid_r;
  logic [OUT_DATA_W-1:0]     out_tdata_r;
  logic                      out_tlast_r;

  assign advance   = !s1_valid_r || !s1_ctl_r.emit || !out_tvalid_r || out_tready;
  assign in_tready = advance;
  assign accept    = in_tvalid && advance;

  mpgd_scan #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_FACTOR (MAX_FACTOR)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .accept     (accept),
    .cell_value (in_tdata),
    .ctl        (scan_ctl),
    .target_col (scan_col),
    .target_row (scan_row),
    .block_max  (scan_max)
  );

  always_comb begin
    line_val = s1_fwd_r ? s1_fwd_data_r : mem_rd_data;
    if (s1_ctl_r.use_line && (line_val > s1_max_r)) begin
      combined = line_val;
    end else begin
      combined = s1_max_r;
    end
    mem_wr_en  = s1_valid_r && s1_ctl_r.store && advance;
    mem_rd_en  = accept && scan_ctl.use_line;
    s1_fwd_nxt = mem_wr_en && (s1_col_r == scan_col);
    col_ext    = 32'(s1_col_r);
  end

  mpgd_line_store #(
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (COL_W)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (s1_col_r),
    .wr_data (combined),
    .rd_en   (mem_rd_en),
    .rd_addr (scan_col),
    .rd_data (mem_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctl_r      <= scan_ctl;
      s1_col_r      <= scan_col;
      s1_row_r      <= scan_row;
      s1_max_r      <= scan_max;
      s1_fwd_r      <= s1_fwd_nxt;
      s1_fwd_data_r <= combined;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (s1_valid_r && s1_ctl_r.emit && advance) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_ctl_r.emit && advance) begin
      out_tdata_r <= {{OUT_PAD_W{1'b0}}, s1_row_r, col_ext[COORD_W-1:0], combined};
      out_tlast_r <= s1_ctl_r.frame_end;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

endmodule

`default_nettype wire

// ===== design/mpgd_line_store.sv =====
// Line store of partial column maxima: one write port and one read port.
// Read data is registered. Uses mpgd_pkg.
`default_nettype none

module mpgd_line_store
  import mpgd_pkg::*;
#(
  parameter int DEPTH  = 2048,
  parameter int ADDR_W = 11
) (
  input  wire                      clk,
  input  wire                      wr_en,
  input  wire [ADDR_W-1:0]         wr_addr,
  input  wire signed [VALUE_W-1:0] wr_data,
  input  wire                      rd_en,
  input  wire [ADDR_W-1:0]         rd_addr,
  output logic signed [VALUE_W-1:0] rd_data
);

  logic signed [VALUE_W-1:0] mem [DEPTH];
  logic signed [VALUE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== design/mpgd_scan.sv =====
// Position tracking and running maximum of the first stage.
// Holds the clamped grid sizes, the raster counters and the block-row maximum. Uses mpgd_pkg.
`default_nettype none

module mpgd_scan
  import mpgd_pkg::*;
#(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_FACTOR = 16,
  localparam int COL_W     = $clog2(MAX_WIDTH),
  localparam int FCW       = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       cfg_we,
  input  wire [CFG_IDX_W-1:0]       cfg_index,
  input  wire [CFG_DATA_W-1:0]      cfg_wdata,
  input  wire                       accept,
  input  wire signed [VALUE_W-1:0]  cell_value,
  output mpgd_ctl_t                 ctl,
  output logic [COL_W-1:0]          target_col,
  output logic [ROW_W-1:0]          target_row,
  output logic signed [VALUE_W-1:0] block_max
);

  logic [COL_W-1:0] width_last_r, width_last_nxt;
  logic [ROW_W-1:0] height_last_r, height_last_nxt;
  logic [FCW-1:0]   factor_last_r, factor_last_nxt;

  logic [COL_W-1:0] src_col_r;
  logic [ROW_W-1:0] src_row_r;
  logic [FCW-1:0]   col_in_block_r;
  logic [FCW-1:0]   row_in_block_r;
  logic [COL_W-1:0] out_col_r;
  logic [ROW_W-1:0] out_row_r;
  logic signed [VALUE_W-1:0] run_max_r, run_max_nxt;

  logic [31:0] size_val;
  logic [31:0] factor_val;
  logic [31:0] width_last32;
  logic [31:0] height_last32;
  logic [31:0] factor_last32;
  logic        cfg_hit;

  logic col_end;
  logic row_end;
  logic block_rows_end;
  logic frame_end;

  always_comb begin
    size_val   = 32'(cfg_wdata[SIZE_FIELD_W-1:0]);
    factor_val = 32'(cfg_wdata[FACTOR_FIELD_W-1:0]);

    if (size_val == 32'd0) begin
      width_last32 = 32'd0;
    end else if (size_val > 32'(MAX_WIDTH)) begin
      width_last32 = 32'(MAX_WIDTH - 1);
    end else begin
      width_last32 = size_val - 32'd1;
    end

    if (size_val == 32'd0) begin
      height_last32 = 32'd0;
    end else if (size_val > 32'(HEIGHT_LIMIT)) begin
      height_last32 = 32'(HEIGHT_LIMIT - 1);
    end else begin
      height_last32 = size_val - 32'd1;
    end

    if (factor_val == 32'd0) begin
      factor_last32 = 32'd0;
    end else if (factor_val > 32'(MAX_FACTOR)) begin
      factor_last32 = 32'(MAX_FACTOR - 1);
    end else begin
      factor_last32 = factor_val - 32'd1;
    end

    width_last_nxt  = width_last32[COL_W-1:0];
    height_last_nxt = height_last32[ROW_W-1:0];
    factor_last_nxt = factor_last32[FCW-1:0];

    cfg_hit = cfg_we && ((cfg_index == CFG_SOURCE_WIDTH) ||
                         (cfg_index == CFG_SOURCE_HEIGHT) ||
                         (cfg_index == CFG_POOL_FACTOR));
  end

  always_comb begin
    row_end        = (src_col_r == width_last_r);
    col_end        = (col_in_block_r == factor_last_r) || row_end;
    block_rows_end = (row_in_block_r == factor_last_r) || (src_row_r == height_last_r);
    frame_end      = row_end && (src_row_r == height_last_r);

    if ((col_in_block_r == '0) || (cell_value > run_max_r)) begin
      run_max_nxt = cell_value;
    end else begin
      run_max_nxt = run_max_r;
    end

    ctl.use_line  = col_end && (row_in_block_r != '0);
    ctl.store     = col_end && !block_rows_end;
    ctl.emit      = col_end && block_rows_end;
    ctl.frame_end = frame_end;
  end

  assign target_col = out_col_r;
  assign target_row = out_row_r;
  assign block_max  = run_max_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_last_r  <= COL_W'(((MAX_WIDTH < 2048) ? MAX_WIDTH : 2048) - 1);
      height_last_r <= ROW_W'(HEIGHT_LIMIT - 1);
      factor_last_r <= FCW'(((MAX_FACTOR < 2) ? MAX_FACTOR : 2) - 1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SOURCE_WIDTH:  width_last_r  <= width_last_nxt;
        CFG_SOURCE_HEIGHT: height_last_r <= height_last_nxt;
        CFG_POOL_FACTOR:   factor_last_r <= factor_last_nxt;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_hit) begin
      src_col_r      <= '0;
      src_row_r      <= '0;
      col_in_block_r <= '0;
      row_in_block_r <= '0;
      out_col_r      <= '0;
      out_row_r      <= '0;
      run_max_r      <= '0;
    end else if (accept) begin
      run_max_r <= run_max_nxt;
      if (row_end) begin
        src_col_r      <= '0;
        col_in_block_r <= '0;
        out_col_r      <= '0;
        if (frame_end) begin
          src_row_r      <= '0;
          row_in_block_r <= '0;
          out_row_r      <= '0;
        end else begin
          src_row_r <= src_row_r + 1'b1;
          if (block_rows_end) begin
            row_in_block_r <= '0;
            out_row_r      <= out_row_r + 1'b1;
          end else begin
            row_in_block_r <= row_in_block_r + 1'b1;
          end
        end
      end else begin
        src_col_r <= src_col_r + 1'b1;
        if (col_end) begin
          col_in_block_r <= '0;
          out_col_r      <= out_col_r + 1'b1;
        end else begin
          col_in_block_r <= col_in_block_r + 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for max_pool_grid_downsample: a directed script, edge runs, then random
// grid frames, with every pooled cell checked against a scripted value or a behavioural model.
// Depends on mpgd_pkg and the max_pool_grid_downsample RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mpgd_pkg::*;

  localparam int GRID_MAX_W    = 2048;
  localparam int FACTOR_MAX    = 16;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 5000;
  localparam int RANDOM_ITEMS  = 1300;
  localparam int EDGE_ITEMS    = 256;
  localparam int FIELD_MASK_W  = CFG_DATA_W - FACTOR_FIELD_W;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [COORD_W-1:0] col;
    logic [ROW_W-1:0]   row;
    logic               fr_last;
  } pooled_t;

  typedef enum logic {ROW_CFG, ROW_CELL} step_kind_t;

  typedef struct {
    step_kind_t           kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DATA_W-1:0] data;
    logic [VALUE_W-1:0]   cell_val;
    bit                   typed;
    pooled_t              want;
  } script_row_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
  logic                  in_tvalid  = 1'b0;
  wire                   in_tready;
  logic [VALUE_W-1:0]    in_tdata   = '0;
  wire                   out_tvalid;
  logic                  out_tready = 1'b0;
  wire [OUT_DATA_W-1:0]  out_tdata;
  wire                   out_tlast;

  max_pool_grid_downsample i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int errors        = 0;
  int idle_cycles   = 0;
  int random_sent   = 0;
  int phase_no      = 0;

  pooled_t     pooled_q [$];
  script_row_t script   [$];

  // Pooling model state
  logic signed [7:0]     colmax_line [GRID_MAX_W];
  logic signed [7:0]     block_max;
  int unsigned           src_col, src_row, col_blk, row_blk, pool_col, pool_row;
  logic [SIZE_FIELD_W-1:0]   width_reg, height_reg;
  logic [FACTOR_FIELD_W-1:0] factor_reg;

  function automatic int unsigned clamp_size(input int unsigned v, input int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void restart_grid();
    block_max = '0;
    src_col   = 0;
    src_row   = 0;
    col_blk   = 0;
    row_blk   = 0;
    pool_col  = 0;
    pool_row  = 0;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_SOURCE_WIDTH:  width_reg  = data[SIZE_FIELD_W-1:0];
      CFG_SOURCE_HEIGHT: height_reg = data[SIZE_FIELD_W-1:0];
      CFG_POOL_FACTOR:   factor_reg = data[FACTOR_FIELD_W-1:0];
      default:           return;
    endcase
    restart_grid();
  endfunction

  function automatic bit pool_cell(input logic signed [7:0] v, output pooled_t res);
    int unsigned       w, h, f, slot;
    bit                col_end, row_end, rows_end, frame_end, has;
    logic signed [7:0] comb;
    w         = clamp_size(width_reg, GRID_MAX_W);
    h         = clamp_size(height_reg, HEIGHT_LIMIT);
    f         = clamp_size(factor_reg, FACTOR_MAX);
    slot      = pool_col % GRID_MAX_W;
    col_end   = (col_blk + 1 >= f) || (src_col + 1 >= w);
    row_end   = (src_col + 1 >= w);
    rows_end  = (row_blk + 1 >= f) || (src_row + 1 >= h);
    frame_end = row_end && (src_row + 1 >= h);
    has       = 1'b0;
    res       = '0;
    if (col_blk == 0 || v > block_max) block_max = v;
    if (col_end) begin
      comb = block_max;
      if (row_blk != 0 && colmax_line[slot] > comb) comb = colmax_line[slot];
      if (rows_end) begin
        res = {comb, pool_col[COORD_W-1:0], pool_row[ROW_W-1:0], frame_end};
        has = 1'b1;
      end else begin
        colmax_line[slot] = comb;
      end
      col_blk = 0;
      pool_col++;
    end else begin
      col_blk++;
    end
    src_col++;
    if (row_end) begin
      src_col  = 0;
      col_blk  = 0;
      pool_col = 0;
      if (rows_end) begin
        row_blk = 0;
        pool_row++;
      end else begin
        row_blk++;
      end
      src_row++;
      if (frame_end) begin
        src_row  = 0;
        row_blk  = 0;
        pool_row = 0;
      end
    end
    return has;
  endfunction

  function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
    script_row_t r;
    r.kind     = ROW_CFG;
    r.idx      = idx;
    r.data     = data;
    r.cell_val = '0;
    r.typed    = 1'b0;
    r.want     = '0;
    script.push_back(r);
  endfunction

  function automatic void add_cell(input logic [VALUE_W-1:0] v, input bit typed = 1'b0,
                                   input logic [VALUE_W-1:0] pv = '0, input int col = 0,
                                   input int row = 0, input bit fl = 1'b0);
    script_row_t r;
    r.kind     = ROW_CELL;
    r.idx      = '0;
    r.data     = '0;
    r.cell_val = v;
    r.typed    = typed;
    r.want     = {pv, col[COORD_W-1:0], row[ROW_W-1:0], fl};
    script.push_back(r);
  endfunction

  task automatic settle();
    in_tvalid <= 1'b0;
    while (pooled_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_reg(idx, data);
  endtask

  task automatic feed_cell(input logic [VALUE_W-1:0] v, input bit typed, input pooled_t want);
    pooled_t got;
    bit      has;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    do @(posedge clk); while (!in_tready);
    has = pool_cell(v, got);
    if (typed) pooled_q.push_back(want);
    else if (has) pooled_q.push_back(got);
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                           input logic [CFG_DATA_W-1:0] fdata, input int n, input int pause);
    logic [VALUE_W-1:0] v;
    write_reg(CFG_SOURCE_WIDTH, w);
    write_reg(CFG_SOURCE_HEIGHT, h);
    write_reg(CFG_POOL_FACTOR, fdata);
    for (int i = 0; i < n; i++) begin
      if (i == pause) settle();
      if ($urandom_range(7, 0) == 0) v = $urandom_range(1, 0) ? 8'h7F : 8'h80;
      else v = 8'($urandom);
      feed_cell(v, 1'b0, '0);
    end
  endtask

  task automatic random_phases(input int target);
    int unsigned w, h, f, frame, n;
    logic [CFG_DATA_W-1:0] fdata;
    while (random_sent < target) begin
      w = ($urandom_range(15, 0) == 0) ? 0 : $urandom_range(48, 1);
      h = ($urandom_range(15, 0) == 0) ? 0 : $urandom_range(24, 1);
      if ($urandom_range(15, 0) == 0) w = $urandom_range(4095, 2049);
      if ($urandom_range(15, 0) == 0) h = $urandom_range(4095, 2049);
      case ($urandom_range(3, 0))
        0:       f = $urandom_range(4, 1);
        1:       f = $urandom_range(16, 5);
        2:       f = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(31, 17);
        default: f = $urandom_range(16, 1);
      endcase
      fdata = {FIELD_MASK_W'($urandom), FACTOR_FIELD_W'(f)};
      frame = clamp_size(w, GRID_MAX_W) * clamp_size(h, HEIGHT_LIMIT);
      if (frame > 400) frame = 400;
      n = frame * $urandom_range(2, 1);
      if ($urandom_range(3, 0) == 0) n = $urandom_range(frame, 1);
      if (n > 400) n = 400;
      phase_no++;
      run_phase(CFG_DATA_W'(w), CFG_DATA_W'(h), fdata, n,
                (phase_no % 3 == 0) ? int'($urandom_range(n - 1, 0)) : -1);
      random_sent += n;
    end
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
  end

  always @(posedge clk) begin : check_pooled
    pooled_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[VALUE_W-1:0], out_tdata[VALUE_W +: COORD_W],
             out_tdata[VALUE_W + COORD_W +: ROW_W], out_tlast};
      if (pooled_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected pooled cell, expected none,", $time,
                 " got value %0d col %0d row %0d last %b",
                 $signed(got.value), got.col, got.row, got.fr_last);
      end else begin
        want = pooled_q.pop_front();
        if (got !== want || out_tdata[OUT_DATA_W-1 -: OUT_PAD_W] !== '0) begin
          errors++;
          $display("%0t: pooled cell mismatch,", $time,
                   " expected value %0d col %0d row %0d last %b pad 0,",
                   $signed(want.value), want.col, want.row, want.fr_last,
                   " got value %0d col %0d row %0d last %b pad %0d",
                   $signed(got.value), got.col, got.row, got.fr_last,
                   out_tdata[OUT_DATA_W-1 -: OUT_PAD_W]);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    foreach (colmax_line[i]) colmax_line[i] = '0;
    width_reg  = 12'd2048;
    height_reg = 12'd2048;
    factor_reg = 5'd2;
    restart_grid();

    // One-cell frames: every cell is its own block and ends the frame.
    add_cfg(CFG_SOURCE_WIDTH, 12'd1);
    add_cfg(CFG_SOURCE_HEIGHT, 12'd1);
    add_cfg(CFG_POOL_FACTOR, 12'd1);
    add_cell(8'h7F, 1'b1, 8'h7F, 0, 0, 1'b1);
    add_cell(8'h80, 1'b1, 8'h80, 0, 0, 1'b1);
    add_cell(8'h00);
    add_cell(8'hFF);
    // A zero factor behaves as one; the bits above the factor field are ignored.
    add_cfg(CFG_POOL_FACTOR, 12'hFE0);
    add_cell(8'h55, 1'b1, 8'h55, 0, 0, 1'b1);
    // Zero width and height behave as one.
    add_cfg(CFG_SOURCE_WIDTH, 12'd0);
    add_cfg(CFG_SOURCE_HEIGHT, 12'd0);
    add_cell(8'hAA, 1'b1, 8'hAA, 0, 0, 1'b1);
    // A 3 by 2 grid pooled by 2: one full block and one partial block at the right edge.
    add_cfg(CFG_SOURCE_WIDTH, 12'd3);
    add_cfg(CFG_SOURCE_HEIGHT, 12'd2);
    add_cfg(CFG_POOL_FACTOR, 12'd2);
    add_cell(8'h80);
    add_cell(8'h7F);
    add_cell(8'h01);
    add_cell(8'hFB);
    add_cell(8'h80, 1'b1, 8'h7F, 0, 0, 1'b0);
    add_cell(8'h00, 1'b1, 8'h01, 1, 0, 1'b1);
    // A write to the unused index changes nothing and keeps the frame position.
    add_cfg(CFG_SOURCE_WIDTH, 12'd2);
    add_cfg(CFG_SOURCE_HEIGHT, 12'd1);
    add_cell(8'h07);
    add_cfg(CFG_SPARE, 12'hFFF);
    add_cell(8'hFD, 1'b1, 8'h07, 0, 0, 1'b1);
    // An oversized factor saturates; a register write part way through restarts the frame.
    add_cfg(CFG_SOURCE_WIDTH, 12'd5);
    add_cfg(CFG_POOL_FACTOR, 12'd31);
    add_cell(8'h01);
    add_cell(8'h02);
    add_cell(8'h03);
    add_cfg(CFG_SOURCE_HEIGHT, 12'd1);
    add_cell(8'hF9);
    add_cell(8'hFA);
    add_cell(8'hFB);
    add_cell(8'hFC);
    add_cell(8'hFD, 1'b1, 8'hFD, 0, 0, 1'b1);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 36;
    recv_idle_pct = 72;
    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG) write_reg(script[i].idx, script[i].data);
      else feed_cell(script[i].cell_val, script[i].typed, script[i].want);
    end

    // Start of the widest row, saturated from the largest width code, one cell per block.
    run_phase(12'hFFF, 12'd1, 12'd1, EDGE_ITEMS, EDGE_ITEMS / 2);
    random_phases(RANDOM_ITEMS / 3);

    send_idle_pct = 72;
    recv_idle_pct = 36;
    // Top of the tallest grid, saturated from the largest height code, one column wide.
    run_phase(12'd1, 12'hFFF, 12'd1, EDGE_ITEMS, EDGE_ITEMS / 3);
    random_phases(2 * RANDOM_ITEMS / 3);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phases(RANDOM_ITEMS);

    settle();
    if (pooled_q.size() != 0) begin
      errors++;
      $display("%0t: %0d pooled cells expected but never received", $time, pooled_q.size());
    end
    if (errors == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule
